// File: hw/rtl/ogd_pkg.sv
package ogd_pkg;

	// Field widths
	localparam int OCC_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Item modes
	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_POINT = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TO_CELL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_USED_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_USED_Y  = 3'd5;

	// Register reset values
	localparam logic [23:0] INV_CELL_SIZE_RST = 24'd32768;
	localparam logic [15:0] PIXEL_TO_CELL_RST = 16'd3277;
	localparam logic [6:0]  CELLS_USED_RST    = 7'd64;

	// Occupancy levels
	localparam logic [OCC_W-1:0] OCC_FULL       = 7'd100;
	localparam logic [OCC_W-1:0] OCC_MARK_LIMIT = 7'd50;

	// One grid entry
	typedef struct packed {
		logic             stat;
		logic [OCC_W-1:0] occ;
	} cell_t;

endpackage

// File: hw/rtl/ogd_if.sv
// Input item channel
interface ogd_in_if import ogd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [13:0]        pixel_col;
	logic [13:0]        pixel_row;
	logic signed [7:0]  pixel_value;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [5:0]         query_col;
	logic [5:0]         query_row;

	modport source (output valid, mode, pixel_col, pixel_row, pixel_value, point_x, point_y,
		query_col, query_row, input ready);
	modport sink (input valid, mode, pixel_col, pixel_row, pixel_value, point_x, point_y,
		query_col, query_row, output ready);
endinterface

// Result channel
interface ogd_out_if import ogd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             in_range;
	logic             marked;
	logic             graph_changed;
	logic [OCC_W-1:0] occupancy;
	logic             is_static;

	modport source (output valid, in_range, marked, graph_changed, occupancy, is_static,
		input ready);
	modport sink (input valid, in_range, marked, graph_changed, occupancy, is_static,
		output ready);
endinterface

// Register write channel
interface ogd_cfg_if import ogd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/ogd_cell_mem.sv
// Grid store: one write port, one read port, registered read data
module ogd_cell_mem import ogd_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_data
);

	cell_t mem_q [DEPTH];
	cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/occupancy_grid_decay.sv
// Occupancy grid with decay. The grid holds GRID_X by GRID_Y cells, each an occupancy of
// 0..100 and a static mark, in one synchronous memory (cell (col,row) at col*GRID_Y+row).
// A map pixel, an obstacle point or a read goes from accept to result through input
// register, coordinate multiply, memory read, then modify and write back. A tick sweeps the
// cells in use through the memory's single read port, one cell a cycle. Input ready is
// high only between items; a finished result waits in the output register while the next
// word is accepted. After reset the store is cleared by a pass over all GRID_X*GRID_Y
// cells during which no input word is taken; register writes are accepted at any time.
module occupancy_grid_decay import ogd_pkg::*; #(
	parameter int GRID_X = 64,
	parameter int GRID_Y = 64
) (
	input logic clk,
	input logic arst_n,
	ogd_in_if.sink   item_in,
	ogd_out_if.source item_out,
	ogd_cfg_if.sink  cfg
);

	localparam int CELLS  = GRID_X * GRID_Y;
	localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW     = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int RW     = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int UXMAX  = (GRID_X > 127) ? 127 : GRID_X;
	localparam int UYMAX  = (GRID_Y > 127) ? 127 : GRID_Y;
	localparam int CNTW   = 11;
	localparam int CELLW  = 25;

	// State codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ADDR  = 3'd3;
	localparam logic [2:0] ST_RMW   = 3'd4;
	localparam logic [2:0] ST_TICK  = 3'd5;
	localparam logic [2:0] ST_TDONE = 3'd6;

	logic [2:0] state_q;

	// Configuration registers
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_y_q;
	logic [23:0]        inv_cell_size_q;
	logic [15:0]        pixel_to_cell_q;
	logic [6:0]         cells_used_x_q;
	logic [6:0]         cells_used_y_q;

	// Accepted item
	logic [1:0]         mode_q;
	logic [13:0]        pix_col_q;
	logic [13:0]        pix_row_q;
	logic [7:0]         pix_val_q;
	logic signed [32:0] dx_q;
	logic signed [32:0] dy_q;
	logic [5:0]         qcol_q;
	logic [5:0]         qrow_q;

	// Cell mapping and access pipeline
	logic [CELLW-1:0] col_s1;
	logic [CELLW-1:0] row_s1;
	logic             neg_s1;
	logic             ok_s2;
	logic [AW-1:0]    addr_s2;

	// Tick sweep
	logic [CW-1:0] tcol_q;
	logic [RW-1:0] trow_q;
	logic          tvld_s1;
	logic [AW-1:0] taddr_s1;
	logic          chg_q;
	logic          pending_q;

	// Clearing pass
	logic [AW-1:0] clr_q;

	// Output register
	logic             out_valid_q;
	logic             out_in_range_q;
	logic             out_marked_q;
	logic             out_changed_q;
	logic [OCC_W-1:0] out_occ_q;
	logic             out_stat_q;

	// Memory ports
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	cell_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	cell_t         wr_data;

	ogd_cell_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Grid extent in use
	logic [6:0] ux;
	logic [6:0] uy;
	assign ux = (cells_used_x_q < 7'(UXMAX)) ? cells_used_x_q : 7'(UXMAX);
	assign uy = (cells_used_y_q < 7'(UYMAX)) ? cells_used_y_q : 7'(UYMAX);

	// Handshakes
	logic in_fire;
	logic emit_ok;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_fire       = item_in.valid && item_in.ready;
	assign emit_ok       = !out_valid_q || item_out.ready;
	assign cfg.ready     = 1'b1;

	// Offsets from the origin, taken at accept
	logic signed [32:0] dx_w;
	logic signed [32:0] dy_w;
	assign dx_w = 33'(item_in.point_x) - 33'(origin_x_q);
	assign dy_w = 33'(item_in.point_y) - 33'(origin_y_q);

	// Coordinate multiplies
	logic signed [24:0] inv_s;
	logic signed [57:0] px_w;
	logic signed [57:0] py_w;
	logic [29:0]        ppc_col_w;
	logic [29:0]        ppc_row_w;
	assign inv_s     = $signed({1'b0, inv_cell_size_q});
	assign px_w      = dx_q * inv_s;
	assign py_w      = dy_q * inv_s;
	assign ppc_col_w = 30'(pix_col_q) * 30'(pixel_to_cell_q);
	assign ppc_row_w = 30'(pix_row_q) * 30'(pixel_to_cell_q);

	logic [CELLW-1:0] col_w;
	logic [CELLW-1:0] row_w;
	logic             neg_w;
	always_comb begin
		col_w = '0;
		row_w = '0;
		neg_w = 1'b0;
		case (mode_q)
			MODE_PIXEL: begin
				col_w = CELLW'(ppc_col_w[29:16]);
				row_w = CELLW'(ppc_row_w[29:16]);
			end
			MODE_POINT: begin
				col_w = px_w[56:32];
				row_w = py_w[56:32];
				neg_w = px_w[57] || py_w[57];
			end
			MODE_READ: begin
				col_w = CELLW'(qcol_q);
				row_w = CELLW'(qrow_q);
			end
			default: ;
		endcase
	end

	// Range check and entry address
	logic          ok_w;
	logic [AW-1:0] addr_w;
	assign ok_w   = !neg_s1 && (col_s1 < CELLW'(ux)) && (row_s1 < CELLW'(uy));
	assign addr_w = AW'(int'(col_s1[CW-1:0]) * GRID_Y + int'(row_s1[RW-1:0]));

	// Modify step for pixel and point items
	cell_t rmw_new;
	logic  rmw_wr;
	logic  rmw_mark;
	always_comb begin
		rmw_new  = rd_data;
		rmw_wr   = 1'b0;
		rmw_mark = 1'b0;
		case (mode_q)
			MODE_PIXEL: begin
				if (ok_s2 && rd_data.occ == '0 && pix_val_q != '0) begin
					rmw_new.occ  = OCC_W'(1);
					rmw_new.stat = 1'b1;
					rmw_wr       = 1'b1;
				end
			end
			MODE_POINT: begin
				if (ok_s2 && rd_data.occ <= OCC_MARK_LIMIT) begin
					rmw_new.occ = OCC_FULL;
					rmw_wr      = 1'b1;
					rmw_mark    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Tick sweep position and decay
	logic [AW-1:0] taddr_w;
	logic          last_row;
	logic          last_col;
	logic          tdec;
	logic          tzero;
	assign taddr_w  = AW'(int'(tcol_q) * GRID_Y + int'(trow_q));
	assign last_row = CNTW'(trow_q) == (CNTW'(uy) - CNTW'(1));
	assign last_col = CNTW'(tcol_q) == (CNTW'(ux) - CNTW'(1));
	assign tdec     = tvld_s1 && !rd_data.stat && rd_data.occ != '0;
	assign tzero    = tdec && rd_data.occ == OCC_W'(1);

	// Memory read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_w;
		if (state_q == ST_ADDR) begin
			rd_en = 1'b1;
		end else if (state_q == ST_TICK) begin
			rd_en   = 1'b1;
			rd_addr = taddr_w;
		end
	end

	// Memory write port: clearing pass, tick writeback, item writeback
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s2;
		wr_data = rmw_new;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (tdec) begin
			wr_en       = 1'b1;
			wr_addr     = taddr_s1;
			wr_data     = rd_data;
			wr_data.occ = rd_data.occ - OCC_W'(1);
		end else if (state_q == ST_RMW && emit_ok && rmw_wr) begin
			wr_en = 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			inv_cell_size_q <= INV_CELL_SIZE_RST;
			pixel_to_cell_q <= PIXEL_TO_CELL_RST;
			cells_used_x_q  <= CELLS_USED_RST;
			cells_used_y_q  <= CELLS_USED_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_ORIGIN_X:      origin_x_q      <= $signed(cfg.data);
				CFG_ORIGIN_Y:      origin_y_q      <= $signed(cfg.data);
				CFG_INV_CELL_SIZE: inv_cell_size_q <= cfg.data[23:0];
				CFG_PIXEL_TO_CELL: pixel_to_cell_q <= cfg.data[15:0];
				CFG_CELLS_USED_X:  cells_used_x_q  <= cfg.data[6:0];
				CFG_CELLS_USED_Y:  cells_used_y_q  <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// Item capture and pipeline payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q    <= item_in.mode;
			pix_col_q <= item_in.pixel_col;
			pix_row_q <= item_in.pixel_row;
			pix_val_q <= item_in.pixel_value;
			dx_q      <= dx_w;
			dy_q      <= dy_w;
			qcol_q    <= item_in.query_col;
			qrow_q    <= item_in.query_row;
		end
		if (state_q == ST_MUL) begin
			col_s1 <= col_w;
			row_s1 <= row_w;
			neg_s1 <= neg_w;
		end
		if (state_q == ST_ADDR) begin
			ok_s2   <= ok_w;
			addr_s2 <= addr_w;
		end
		taddr_s1 <= taddr_w;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			tcol_q    <= '0;
			trow_q    <= '0;
			tvld_s1   <= 1'b0;
			chg_q     <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			tvld_s1 <= (state_q == ST_TICK);
			if (tzero) begin
				chg_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						tcol_q  <= '0;
						trow_q  <= '0;
						chg_q   <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mode_q == MODE_TICK) begin
						state_q <= (ux == '0 || uy == '0) ? ST_TDONE : ST_TICK;
					end else begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_RMW;
				end
				ST_RMW: begin
					if (emit_ok) begin
						if (rmw_mark) begin
							pending_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (last_row) begin
						trow_q <= '0;
						if (last_col) begin
							state_q <= ST_TDONE;
						end else begin
							tcol_q <= tcol_q + CW'(1);
						end
					end else begin
						trow_q <= trow_q + RW'(1);
					end
				end
				ST_TDONE: begin
					if (emit_ok) begin
						pending_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RMW || state_q == ST_TDONE) && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RMW && emit_ok) begin
			out_in_range_q <= ok_s2;
			out_marked_q   <= rmw_mark;
			out_changed_q  <= 1'b0;
			out_occ_q      <= ok_s2 ? rmw_new.occ : '0;
			out_stat_q     <= ok_s2 && rmw_new.stat;
		end else if (state_q == ST_TDONE && emit_ok) begin
			out_in_range_q <= 1'b0;
			out_marked_q   <= 1'b0;
			out_changed_q  <= pending_q || chg_q || tzero;
			out_occ_q      <= '0;
			out_stat_q     <= 1'b0;
		end
	end

	assign item_out.valid         = out_valid_q;
	assign item_out.in_range      = out_in_range_q;
	assign item_out.marked        = out_marked_q;
	assign item_out.graph_changed = out_changed_q;
	assign item_out.occupancy     = out_occ_q;
	assign item_out.is_static     = out_stat_q;

`ifndef NO_ASSERTIONS
	// Reported occupancy never exceeds full
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid |-> item_out.occupancy <= OCC_FULL)
		else $error("occupancy above full");

	// A mark leaves its cell in range at full occupancy
	a_mark_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.marked |-> item_out.in_range && item_out.occupancy == OCC_FULL)
		else $error("marked word without full cell");

	// Tick writeback only follows a sweep read
	a_tick_wb: assert property (@(posedge clk) disable iff (!arst_n)
		tvld_s1 |-> state_q == ST_TICK || state_q == ST_TDONE)
		else $error("tick writeback outside sweep");

	// No input word is taken while the store is being cleared
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !item_in.ready)
		else $error("input ready during clearing pass");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ogd_pkg::*;

	localparam int GX           = 64;
	localparam int GY           = 64;
	localparam int CELL_COUNT   = GX * GY;
	localparam int GAP_PCT      = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;

	// One input word as the testbench builds it
	typedef struct {
		logic [1:0]         mode;
		logic [13:0]        pix_col;
		logic [13:0]        pix_row;
		logic signed [7:0]  pix_val;
		logic signed [31:0] pt_x;
		logic signed [31:0] pt_y;
		logic [5:0]         q_col;
		logic [5:0]         q_row;
	} grid_word_t;

	// One report word
	typedef struct {
		logic             in_range;
		logic             marked;
		logic             graph_changed;
		logic [OCC_W-1:0] occupancy;
		logic             is_static;
	} cell_report_t;

	logic clk;
	logic arst_n;
	bit   no_gaps;
	int   mismatches;
	int   cycle_count = 0;

	ogd_in_if  item_if();
	ogd_out_if report_if();
	ogd_cfg_if cfg_if();

	occupancy_grid_decay #(
		.GRID_X(GX),
		.GRID_Y(GY)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_if),
		.item_out(report_if),
		.cfg     (cfg_if)
	);

	// Grid model and register copies
	logic [OCC_W-1:0]   grid_occ [CELL_COUNT];
	bit                 grid_static [CELL_COUNT];
	bit                 change_seen;
	logic signed [31:0] reg_org_x;
	logic signed [31:0] reg_org_y;
	logic [23:0]        reg_inv;
	logic [15:0]        reg_pix;
	logic [6:0]         reg_cols;
	logic [6:0]         reg_rows;

	cell_report_t cell_reports_due[$];
	cell_report_t due_report;

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Report side backpressure
	always @(negedge clk) begin
		report_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
	end

	function automatic int cols_in_use();
		return (int'(reg_cols) < GX) ? int'(reg_cols) : GX;
	endfunction

	function automatic int rows_in_use();
		return (int'(reg_rows) < GY) ? int'(reg_rows) : GY;
	endfunction

	// Q16.16 coordinate to cell; 0 when left of / below the origin
	function automatic bit locate_point(logic signed [31:0] p, logic signed [31:0] org,
		output longint cell_idx);
		longint diff;
		longint prod;
		diff = longint'(p) - longint'(org);
		prod = diff * longint'(reg_inv);
		cell_idx = 0;
		if (prod < 0)
			return 1'b0;
		cell_idx = prod >>> 32;
		return 1'b1;
	endfunction

	// Apply one word to the grid model and return the report it should produce
	function automatic cell_report_t apply_to_grid(grid_word_t w);
		cell_report_t rep;
		longint       col;
		longint       row;
		bit           ok;
		bit           okx;
		bit           oky;
		int           idx;
		int           ux;
		int           uy;
		rep.in_range      = 1'b0;
		rep.marked        = 1'b0;
		rep.graph_changed = 1'b0;
		rep.occupancy     = '0;
		rep.is_static     = 1'b0;
		col = 0;
		row = 0;
		ok  = 1'b0;
		ux  = cols_in_use();
		uy  = rows_in_use();
		case (w.mode)
			MODE_PIXEL: begin
				col = (longint'(w.pix_col) * longint'(reg_pix)) >>> 16;
				row = (longint'(w.pix_row) * longint'(reg_pix)) >>> 16;
				ok  = (col < ux) && (row < uy);
				if (ok) begin
					idx = int'(col) * GY + int'(row);
					if (grid_occ[idx] == 0 && w.pix_val != 0) begin
						grid_occ[idx]    = 1;
						grid_static[idx] = 1'b1;
					end
				end
			end
			MODE_POINT: begin
				okx = locate_point(w.pt_x, reg_org_x, col);
				oky = locate_point(w.pt_y, reg_org_y, row);
				ok  = okx && oky && (col < ux) && (row < uy);
				if (ok) begin
					idx = int'(col) * GY + int'(row);
					if (grid_occ[idx] <= OCC_MARK_LIMIT) begin
						grid_occ[idx] = OCC_FULL;
						change_seen   = 1'b1;
						rep.marked    = 1'b1;
					end
				end
			end
			MODE_TICK: begin
				rep.graph_changed = change_seen;
				for (int c = 0; c < ux; c++) begin
					for (int r = 0; r < uy; r++) begin
						idx = c * GY + r;
						if (!grid_static[idx] && grid_occ[idx] > 0) begin
							grid_occ[idx] = grid_occ[idx] - 1;
							if (grid_occ[idx] == 0)
								rep.graph_changed = 1'b1;
						end
					end
				end
				change_seen = 1'b0;
			end
			default: begin
				col = w.q_col;
				row = w.q_row;
				ok  = (col < ux) && (row < uy);
			end
		endcase
		if (w.mode != MODE_TICK && ok) begin
			idx           = int'(col) * GY + int'(row);
			rep.occupancy = grid_occ[idx];
			rep.is_static = grid_static[idx];
		end
		rep.in_range = ok;
		return rep;
	endfunction

	task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted report word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && report_if.valid === 1'b1 && report_if.ready) begin
			if (cell_reports_due.size() == 0) begin
				$display({"%0t: unexpected report word: expected none, ",
					"got in_range=%b marked=%b changed=%b occ=%0d static=%b"},
					$time, report_if.in_range, report_if.marked, report_if.graph_changed,
					report_if.occupancy, report_if.is_static);
				mismatches++;
			end else begin
				due_report = cell_reports_due.pop_front();
				check_field("in_range", 7'(due_report.in_range), 7'(report_if.in_range));
				check_field("marked", 7'(due_report.marked), 7'(report_if.marked));
				check_field("graph_changed", 7'(due_report.graph_changed),
					7'(report_if.graph_changed));
				check_field("occupancy", due_report.occupancy, report_if.occupancy);
				check_field("is_static", 7'(due_report.is_static), 7'(report_if.is_static));
			end
		end
	end

	// Send one word; valid stays up until the next call or settle()
	task automatic send_word(grid_word_t w);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
			item_if.valid = 1'b0;
			@(negedge clk);
		end
		item_if.mode        = w.mode;
		item_if.pixel_col   = w.pix_col;
		item_if.pixel_row   = w.pix_row;
		item_if.pixel_value = w.pix_val;
		item_if.point_x     = w.pt_x;
		item_if.point_y     = w.pt_y;
		item_if.query_col   = w.q_col;
		item_if.query_row   = w.q_row;
		item_if.valid       = 1'b1;
		do @(posedge clk); while (item_if.ready !== 1'b1);
		cell_reports_due = {cell_reports_due, apply_to_grid(w)};
	endtask

	// Drop valid and let the block run dry
	task automatic settle();
		@(negedge clk);
		item_if.valid = 1'b0;
		while (cell_reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.addr  = idx;
		cfg_if.data  = value;
		cfg_if.valid = 1'b1;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			CFG_ORIGIN_X:      reg_org_x = value;
			CFG_ORIGIN_Y:      reg_org_y = value;
			CFG_INV_CELL_SIZE: reg_inv   = value[23:0];
			CFG_PIXEL_TO_CELL: reg_pix   = value[15:0];
			CFG_CELLS_USED_X:  reg_cols  = value[6:0];
			CFG_CELLS_USED_Y:  reg_rows  = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_geometry(logic [31:0] ox, logic [31:0] oy, logic [23:0] inv,
		logic [15:0] pix, logic [6:0] cols, logic [6:0] rows);
		settle();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_INV_CELL_SIZE, {8'd0, inv});
		write_reg(CFG_PIXEL_TO_CELL, {16'd0, pix});
		write_reg(CFG_CELLS_USED_X, {25'd0, cols});
		write_reg(CFG_CELLS_USED_Y, {25'd0, rows});
	endtask

	// Word builders: fields the mode ignores carry random bits
	function automatic grid_word_t noise_word();
		grid_word_t w;
		w.mode    = 2'($urandom_range(0, 3));
		w.pix_col = 14'($urandom_range(0, 16383));
		w.pix_row = 14'($urandom_range(0, 16383));
		w.pix_val = 8'($urandom_range(0, 255));
		w.pt_x    = $urandom;
		w.pt_y    = $urandom;
		w.q_col   = 6'($urandom_range(0, 63));
		w.q_row   = 6'($urandom_range(0, 63));
		return w;
	endfunction

	function automatic grid_word_t pixel_word(logic [13:0] col, logic [13:0] row,
		logic signed [7:0] val);
		grid_word_t w;
		w         = noise_word();
		w.mode    = MODE_PIXEL;
		w.pix_col = col;
		w.pix_row = row;
		w.pix_val = val;
		return w;
	endfunction

	function automatic grid_word_t point_word(logic signed [31:0] x, logic signed [31:0] y);
		grid_word_t w;
		w      = noise_word();
		w.mode = MODE_POINT;
		w.pt_x = x;
		w.pt_y = y;
		return w;
	endfunction

	function automatic grid_word_t read_word(logic [5:0] col, logic [5:0] row);
		grid_word_t w;
		w       = noise_word();
		w.mode  = MODE_READ;
		w.q_col = col;
		w.q_row = row;
		return w;
	endfunction

	function automatic grid_word_t tick_word();
		grid_word_t w;
		w      = noise_word();
		w.mode = MODE_TICK;
		return w;
	endfunction

	// Coordinate that lands somewhere in the given cell (wraps for far cells)
	function automatic logic signed [31:0] aim_point(int cell_idx, logic signed [31:0] org);
		longint span;
		if (reg_inv == 0)
			return $urandom;
		span = ((longint'(cell_idx) <<< 32) + longint'($urandom())) / longint'(reg_inv);
		return org + span[31:0];
	endfunction

	function automatic logic [13:0] aim_pixel(int cell_idx);
		longint pos;
		if (reg_pix == 0)
			return 14'($urandom_range(0, 16383));
		pos = ((longint'(cell_idx) <<< 16) + longint'($urandom_range(0, 65535)))
			/ longint'(reg_pix);
		return (pos > 16383) ? 14'd16383 : 14'(pos);
	endfunction

	// Random mix, mostly aimed at cells in use or just beyond
	function automatic grid_word_t random_word(int tick_pct);
		grid_word_t w;
		int         pick;
		int         ux;
		int         uy;
		ux   = cols_in_use();
		uy   = rows_in_use();
		w    = noise_word();
		pick = $urandom_range(99);
		if (pick < tick_pct) begin
			w.mode = MODE_TICK;
		end else if (pick < tick_pct + 35) begin
			w.mode = MODE_POINT;
			if ($urandom_range(3) != 0) begin
				w.pt_x = aim_point($urandom_range(0, ux), reg_org_x);
				w.pt_y = aim_point($urandom_range(0, uy), reg_org_y);
			end
		end else if (pick < tick_pct + 60) begin
			w.mode = MODE_PIXEL;
			if ($urandom_range(3) != 0) begin
				w.pix_col = aim_pixel($urandom_range(0, ux));
				w.pix_row = aim_pixel($urandom_range(0, uy));
			end
			if ($urandom_range(4) == 0)
				w.pix_val = 0;
		end else begin
			w.mode = MODE_READ;
			if ($urandom_range(3) != 0) begin
				w.q_col = 6'($urandom_range(0, ux));
				w.q_row = 6'($urandom_range(0, uy));
			end
		end
		return w;
	endfunction

	// Store comes out of reset cleared, nothing pending
	task automatic test_cleared_grid();
		send_word(read_word(0, 0));
		send_word(read_word(63, 63));
		send_word(tick_word());
	endtask

	// Pixel pooling: zero value, free cell, already static cell, off grid
	task automatic test_map_pixels();
		send_word(pixel_word(0, 0, 0));
		send_word(pixel_word(0, 0, -128));
		send_word(pixel_word(0, 0, 127));
		send_word(pixel_word(14'h3fff, 14'h3fff, 127));
		send_word(pixel_word(aim_pixel(63), aim_pixel(63), 1));
		send_word(read_word(63, 63));
	endtask

	// Obstacle marks: static cell, negative offset, far points, full cell
	task automatic test_obstacle_points();
		logic signed [31:0] x;
		logic signed [31:0] y;
		send_word(point_word(0, 0));
		send_word(point_word(-1, 0));
		send_word(point_word(32'sh7fffffff, 32'sh7fffffff));
		send_word(point_word(32'sh80000000, 32'sh80000000));
		x = aim_point(5, reg_org_x);
		y = aim_point(7, reg_org_y);
		send_word(point_word(x, y));
		send_word(point_word(x, y));
		send_word(tick_word());
		send_word(tick_word());
		send_word(read_word(5, 7));
		send_word(read_word(0, 0));
	endtask

	// Shrunk grid keeps cells outside it frozen; zero columns leave nothing in use
	task automatic test_grid_limits();
		settle();
		write_reg(CFG_CELLS_USED_X, 32'd4);
		write_reg(CFG_CELLS_USED_Y, 32'd4);
		send_word(tick_word());
		send_word(read_word(5, 7));
		settle();
		write_reg(CFG_CELLS_USED_X, 32'd0);
		send_word(pixel_word(0, 0, 1));
		send_word(tick_word());
		settle();
		write_reg(CFG_CELLS_USED_X, 32'd127);
		write_reg(CFG_CELLS_USED_Y, 32'd64);
		send_word(read_word(5, 7));
	endtask

	// A mark decays all the way to zero on a tiny grid, back to back words
	task automatic test_decay_to_zero();
		set_geometry(32'd0, 32'd0, INV_CELL_SIZE_RST, PIXEL_TO_CELL_RST, 7'd1, 7'd2);
		no_gaps = 1'b1;
		send_word(point_word(aim_point(0, reg_org_x), aim_point(1, reg_org_y)));
		for (int i = 0; i < 101; i++) begin
			send_word(tick_word());
			if (i % 50 == 49)
				send_word(read_word(0, 1));
		end
		send_word(read_word(0, 0));
		no_gaps = 1'b0;
	endtask

	task automatic run_phase(int count, int tick_pct);
		repeat (count) send_word(random_word(tick_pct));
	endtask

	// Random traffic over several geometries, extremes included
	task automatic test_random_traffic();
		set_geometry(32'd0, 32'd0, INV_CELL_SIZE_RST, PIXEL_TO_CELL_RST,
			CELLS_USED_RST, CELLS_USED_RST);
		run_phase(5, 8);
		set_geometry(-32'sd1 * $urandom_range(1, 32'h7fffff), $urandom,
			24'($urandom_range(32'h10000, 32'h400000)),
			16'($urandom_range(1000, 20000)),
			7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
		run_phase(5, 30);
		set_geometry(32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff, 16'hffff, 7'd64, 7'd1);
		run_phase(5, 25);
		set_geometry($urandom, $urandom, 24'd0, 16'd0, 7'd127, 7'd3);
		run_phase(5, 20);
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		no_gaps    = 1'b0;
		mismatches = 0;

		item_if.valid       = 1'b0;
		item_if.mode        = MODE_READ;
		item_if.pixel_col   = '0;
		item_if.pixel_row   = '0;
		item_if.pixel_value = '0;
		item_if.point_x     = '0;
		item_if.point_y     = '0;
		item_if.query_col   = '0;
		item_if.query_row   = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.addr         = CFG_ORIGIN_X;
		cfg_if.data         = '0;

		// Model state after reset
		reg_org_x   = '0;
		reg_org_y   = '0;
		reg_inv     = INV_CELL_SIZE_RST;
		reg_pix     = PIXEL_TO_CELL_RST;
		reg_cols    = CELLS_USED_RST;
		reg_rows    = CELLS_USED_RST;
		change_seen = 1'b0;
		foreach (grid_occ[i]) begin
			grid_occ[i]    = '0;
			grid_static[i] = 1'b0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_cleared_grid();
		test_map_pixels();
		test_obstacle_points();
		test_grid_limits();
		test_decay_to_zero();
		test_random_traffic();
		settle();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
